FILE: hw/rtl/rrva_pkg.sv
// Shared types for the round robin volume allocator.
// Used by rrva_ctrl, rrva_dp and round_robin_volume_allocator_top.
`default_nettype none

package rrva_pkg;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic grant;
    logic refuse;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic last;
    logic out_free;
  } status_t;

  localparam int unsigned CFG_BITS  = 32;
  localparam int unsigned ITEM_BITS = 32;
  localparam int unsigned VOL_BITS  = 3;
  localparam int unsigned OUT_BYTES = 8;

endpackage

`default_nettype wire

FILE: hw/rtl/round_robin_volume_allocator_top.sv
// Top level of the round robin volume allocator: controller plus datapath.
// Depends on rrva_pkg, rrva_ctrl and rrva_dp.
//
//   channel  direction  payload (low bit first)
//   cfg      in         cfg_wdata = max_space[31:0]
//   s        in         s_tdata   = item_size[31:0]
//   m        out        m_tdata   = granted[0], volume[3:1], zero[7:4]
//
// Each item is accepted, then scanned over one to NUM_VOLUMES volumes, one volume
// per cycle, set by the single read port of the usage memory.
// The next request is taken once the scan ends, even while a result waits.
// A scan that reaches its result holds while the result register is full.
// Reset empties all volumes, marks them available and restarts at volume 1.
`default_nettype none

module round_robin_volume_allocator_top #(
  parameter int unsigned NUM_VOLUMES = 4,
  parameter int unsigned SIZE_BITS   = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [31:0] cfg_wdata,  // max_space
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [31:0] s_tdata,    // item_size
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata     // granted, volume, zero pad
);

  rrva_pkg::cmd_t    cmd;
  rrva_pkg::status_t st;

  rrva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rrva_dp #(
    .NUM_VOLUMES (NUM_VOLUMES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !(cmd.grant && cmd.refuse))
    else $error("grant and refuse in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("transaction accepted while a scan runs");

  a_grant_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |=> (m_tvalid && m_tdata[0] && (m_tdata[3:1] != 3'd0)))
    else $error("grant not presented on the result channel");

  a_refuse_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.refuse |=> (m_tvalid && (m_tdata == 8'd0)))
    else $error("refusal not presented on the result channel");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rrva_ctrl.sv
// Scan controller for the round robin volume allocator.
// Depends on rrva_pkg for state, command and status types.
`default_nettype none

module rrva_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  rrva_pkg::status_t st,
  output rrva_pkg::cmd_t    cmd
);

  rrva_pkg::state_t state;
  rrva_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrva_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      rrva_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = rrva_pkg::ST_SCAN;
        end
      end
      rrva_pkg::ST_SCAN: begin
        if (st.fits) begin
          if (st.out_free) begin
            cmd.grant  = 1'b1;
            state_next = rrva_pkg::ST_IDLE;
          end
        end else if (st.last) begin
          if (st.out_free) begin
            cmd.refuse = 1'b1;
            state_next = rrva_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = rrva_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrva_dp.sv
// Datapath for the round robin volume allocator: usage memory, flags,
// scan pointer, capacity register and result register. Depends on rrva_pkg.
`default_nettype none

module rrva_dp #(
  parameter int unsigned NUM_VOLUMES = 4,
  parameter int unsigned SIZE_BITS   = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [rrva_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  wire  [rrva_pkg::ITEM_BITS-1:0]       s_tdata,
  input  rrva_pkg::cmd_t                       cmd,
  output rrva_pkg::status_t                    st,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [rrva_pkg::OUT_BYTES-1:0]       m_tdata
);

  localparam int unsigned PW    = $clog2(NUM_VOLUMES);
  localparam int unsigned CMP_W =
    ((SIZE_BITS > rrva_pkg::CFG_BITS) ? SIZE_BITS : rrva_pkg::CFG_BITS) + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_VOLUMES - 1);

  logic [SIZE_BITS-1:0]          mem [NUM_VOLUMES];
  logic [SIZE_BITS-1:0]          rdata;
  logic [rrva_pkg::CFG_BITS-1:0] max_space;
  logic [SIZE_BITS-1:0]          size_q;
  logic [NUM_VOLUMES-1:0]        avail;
  logic [NUM_VOLUMES-1:0]        written;
  logic [PW-1:0]                 next_position;
  logic [PW-1:0]                 pos;
  logic [PW-1:0]                 count;

  logic [PW-1:0]                 pos_inc;
  logic [PW-1:0]                 rd_addr;
  logic [SIZE_BITS-1:0]          used;
  logic [CMP_W-1:0]              sum;
  logic [PW:0]                   vol_num;

  assign pos_inc = (pos == LAST_POS) ? '0 : pos + PW'(1);
  assign rd_addr = cmd.start ? next_position : (cmd.step ? pos_inc : pos);
  assign used    = written[pos] ? rdata : '0;
  assign sum     = CMP_W'(used) + CMP_W'(size_q);
  assign vol_num = {1'b0, pos} + (PW + 1)'(1);

  assign st.fits     = avail[pos] && (sum <= CMP_W'(max_space));
  assign st.last     = (count == LAST_POS);
  assign st.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      mem[pos] <= sum[SIZE_BITS-1:0];
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size_q <= SIZE_BITS'(s_tdata);
      pos    <= next_position;
      count  <= '0;
    end else if (cmd.step) begin
      pos   <= pos_inc;
      count <= count + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_space     <= '1;
      avail         <= '1;
      written       <= '0;
      next_position <= '0;
    end else begin
      if (cfg_we) begin
        max_space <= cfg_wdata;
      end
      if (cmd.step || cmd.refuse) begin
        avail[pos] <= 1'b0;
      end
      if (cmd.grant) begin
        written[pos]  <= 1'b1;
        next_position <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.grant || cmd.refuse) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      m_tdata <= {(rrva_pkg::OUT_BYTES - rrva_pkg::VOL_BITS - 1)'(0),
                  rrva_pkg::VOL_BITS'(vol_num), 1'b1};
    end else if (cmd.refuse) begin
      m_tdata <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: dv/volume_allocation_checker.sv
`timescale 1ns / 100ps
// Checker for the round robin volume allocator: predicts each placement and compares results.
// Depends on rrva_pkg; watches the cfg, s and m channels of round_robin_volume_allocator_top.

module volume_allocation_checker #(
  parameter int NUM_VOL = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [rrva_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  wire                           s_tvalid,
  input  wire                           s_tready,
  input  wire [rrva_pkg::ITEM_BITS-1:0] s_tdata,
  input  wire                           m_tvalid,
  input  wire                           m_tready,
  input  wire [7:0]                     m_tdata,
  output int                            mismatches,
  output int                            pending,
  output int                            placed,
  output int                            refused
);

  typedef struct packed {
    logic [3:0]                    pad;
    logic [rrva_pkg::VOL_BITS-1:0] volume;
    logic                          granted;
  } placement_t;

  logic [rrva_pkg::CFG_BITS-1:0]  capacity;
  logic [rrva_pkg::ITEM_BITS-1:0] usage [NUM_VOL];
  logic                           vol_open [NUM_VOL];
  logic [1:0]                     scan_start;
  placement_t                     placement_q [$];

  function automatic placement_t place_item(input logic [rrva_pkg::ITEM_BITS-1:0] size);
    placement_t                   res;
    logic [1:0]                   pos;
    logic [rrva_pkg::ITEM_BITS:0] total;
    res = '0;
    pos = scan_start;
    for (int n = 0; n < NUM_VOL; n++) begin
      if (vol_open[pos]) begin
        total = {1'b0, usage[pos]} + {1'b0, size};
        if (total <= {1'b0, capacity}) begin
          usage[pos]  = total[rrva_pkg::ITEM_BITS-1:0];
          scan_start  = pos + 2'd1;
          res.granted = 1'b1;
          res.volume  = (rrva_pkg::VOL_BITS)'(pos) + (rrva_pkg::VOL_BITS)'(1);
          return res;
        end
        vol_open[pos] = 1'b0;
      end
      pos = pos + 2'd1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (rst) begin
      capacity   = '1;
      scan_start = '0;
      for (int k = 0; k < NUM_VOL; k++) begin
        usage[k]    = '0;
        vol_open[k] = 1'b1;
      end
      placement_q.delete();
    end else begin
      if (cfg_we)
        capacity = cfg_wdata;
      if (s_tvalid && s_tready)
        placement_q.push_back(place_item(s_tdata));
      if (m_tvalid && m_tready) begin
        got = placement_t'(m_tdata);
        if (got.granted)
          placed++;
        else
          refused++;
        if (placement_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding: granted %0b volume %0d",
                   $time, got.granted, got.volume);
        end else begin
          want = placement_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected granted %0b volume %0d pad %0h,",
                     $time, want.granted, want.volume, want.pad);
            $display("  actual granted %0b volume %0d pad %0h",
                     got.granted, got.volume, got.pad);
          end
        end
      end
    end
    pending = placement_q.size();
  end

endmodule

FILE: dv/tb_round_robin_volume_allocator_top.sv
`timescale 1ns / 100ps
// Testbench top for round_robin_volume_allocator_top: clock, reset, stimulus and verdict.
// Depends on rrva_pkg, the block's RTL and volume_allocation_checker.

module tb_round_robin_volume_allocator_top;

  localparam int NUM_VOL     = 4;
  localparam int CYCLE_LIMIT = 600000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [rrva_pkg::CFG_BITS-1:0]  cfg_wdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rrva_pkg::ITEM_BITS-1:0] s_tdata = '0;  // item_size
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;       // granted, volume, zero pad

  int mismatches;
  int pending;
  int placed;
  int refused;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_cycle = 0;
  int rx_hold_until = 0;
  int cycle_count = 0;

  logic [rrva_pkg::ITEM_BITS-1:0] directed_sizes [12] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0005,
    32'h0000_0007, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0001_0000, 32'h0000_0003, 32'h0000_FFFF
  };

  initial begin
    forever #2 clk = ~clk;
  end

  round_robin_volume_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  volume_allocation_checker #(.NUM_VOL(NUM_VOL)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .placed     (placed),
    .refused    (refused)
  );

  // hold off results until rx_hold_until, otherwise stall at random
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    m_tready <= (rx_cycle >= rx_hold_until) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d placements outstanding", $time, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [rrva_pkg::ITEM_BITS-1:0] small_size();
    if ($urandom_range(9) == 0)
      return $urandom_range(0, 32'h0010_0000);
    return $urandom_range(0, 4095);
  endfunction

  task automatic send_item(input logic [rrva_pkg::ITEM_BITS-1:0] size);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= size;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (NUM_VOL + 4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [rrva_pkg::CFG_BITS-1:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int tx_idle, input int rx_stall);
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    repeat (n) send_item(small_size());
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_capacity(32'hFFFF_FFFF);
    foreach (directed_sizes[i]) send_item(directed_sizes[i]);
    drain();

    run_phase(400, 0, 0);
    write_capacity(32'h8000_0000);
    run_phase(400, 82, 0);
    write_capacity($urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
    run_phase(400, 0, 82);
    write_capacity(32'hFFFF_FFFF);
    run_phase(400, 30, 30);

    // long hold on results while the sender keeps offering
    rx_hold_until = rx_cycle + 300;
    run_phase(100, 0, 0);

    // send wide sizes to fill the volumes so that requests are refused
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    repeat (40) send_item($urandom());
    drain();

    write_capacity(32'h0000_0000);
    for (int i = 0; i < 16; i++)
      send_item(i[0] ? (rrva_pkg::ITEM_BITS)'($urandom()) : '0);
    drain();

    $display("Sent %0d requests: %0d placed, %0d refused, capacity from zero to full range,",
             items_sent, placed, refused);
    $display("with random gaps, result stalls and a long hold on the result channel");
    if (pending != 0)
      $display("%0t: %0d placements never returned", $time, pending);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rrva_pkg.sv
hw/rtl/rrva_ctrl.sv
hw/rtl/rrva_dp.sv
hw/rtl/round_robin_volume_allocator_top.sv
dv/volume_allocation_checker.sv
dv/tb_round_robin_volume_allocator_top.sv
